// ===== rtl/clb_pkg.sv =====
// Package for the cursor list buffer: sizes, action codes, payload structs
// and the control types shared by the cells, the stacks and the top level.
// No dependencies.
package clb_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 64;
  // Width of a count that can reach CAPACITY, and of a position below it.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = $clog2(CAPACITY);
  localparam int DATA_W = 8;

  // Action codes of an input request.
  typedef enum logic [2:0] {
    ACT_BEGIN         = 3'd0,
    ACT_END           = 3'd1,
    ACT_NEXT          = 3'd2,
    ACT_PRIOR         = 3'd3,
    ACT_INSERT_AFTER  = 3'd4,
    ACT_INSERT_BEFORE = 3'd5,
    ACT_REMOVE        = 3'd6,
    ACT_REPLACE       = 3'd7
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] removed_value;
    logic [DATA_W-1:0] cursor_value;
    logic [6-1:0]      cursor_position;
    logic [7-1:0]      entry_count;
  } out_item_t;

  // Operation applied to the cells of a stack; a write reaches only the top cell.
  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP,
    STK_WRITE
  } stk_op_t;

  typedef struct packed {
    stk_op_t           op;
    logic [DATA_W-1:0] push_data;
  } stk_ctl_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE_LEFT,
    ST_MOVE_RIGHT,
    ST_DONE
  } ctl_state_t;

endpackage

// ===== rtl/clb_cell.sv =====
// One storage cell of a stack chain: holds a byte and takes its neighbor's.
// Depends on clb_pkg.
module clb_cell (
  input  logic                      clk,
  input  clb_pkg::stk_op_t          op,
  input  logic [clb_pkg::DATA_W-1:0] from_prev,
  input  logic [clb_pkg::DATA_W-1:0] from_next,
  output logic [clb_pkg::DATA_W-1:0] data
);

  logic [clb_pkg::DATA_W-1:0] data_r;
  logic [clb_pkg::DATA_W-1:0] data_nxt;

  // A push or write loads from the cell above, a pop from the cell below.
  always_comb begin
    unique case (op)
      clb_pkg::STK_HOLD:  data_nxt = data_r;
      clb_pkg::STK_PUSH:  data_nxt = from_prev;
      clb_pkg::STK_POP:   data_nxt = from_next;
      clb_pkg::STK_WRITE: data_nxt = from_prev;
      default:            data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ===== rtl/clb_stack.sv =====
// A stack built as a chain of clb_cell; cell 0 is the top of the stack.
// Depends on clb_pkg and clb_cell.
module clb_stack (
  input  logic                       clk,
  input  clb_pkg::stk_ctl_t          ctl,
  output logic [clb_pkg::DATA_W-1:0] top_data
);

  logic [clb_pkg::DATA_W-1:0] cell_data [clb_pkg::CAPACITY];

  // A write touches the top cell only; every other operation goes to all cells.
  for (genvar i = 0; i < clb_pkg::CAPACITY; i++) begin : g_cell
    logic [clb_pkg::DATA_W-1:0] prev_w;
    logic [clb_pkg::DATA_W-1:0] next_w;
    clb_pkg::stk_op_t           op_w;

    if (i == 0) begin : g_top
      assign prev_w = ctl.push_data;
      assign op_w   = ctl.op;
    end else begin : g_body
      assign prev_w = cell_data[i-1];
      assign op_w   = (ctl.op == clb_pkg::STK_WRITE) ? clb_pkg::STK_HOLD : ctl.op;
    end

    if (i == clb_pkg::CAPACITY - 1) begin : g_bottom
      assign next_w = cell_data[i];
    end else begin : g_inner
      assign next_w = cell_data[i+1];
    end

    clb_cell u_cell (
      .clk       (clk),
      .op        (op_w),
      .from_prev (prev_w),
      .from_next (next_w),
      .data      (cell_data[i])
    );
  end

  assign top_data = cell_data[0];

endmodule

// ===== rtl/cursor_list_buffer_unit.sv =====
// Top level of the cursor list buffer: sequencer, counters and result register.
// Depends on clb_pkg and clb_stack.
//
// Usage: an ordered list of up to 64 bytes with one cursor. Each input request
// (in_valid/in_ready, in_data) carries an action and a byte; each request gives
// exactly one result (out_valid/out_ready, out_data) with the success flag, the
// removed byte, the byte and position at the cursor and the entry count.
// The list is held as two stacks of cells: the left stack holds the entries in
// front of the cursor, the right stack the entry at the cursor and those after
// it, so the cursor byte is always the top cell of the right stack.
// Begin, end and a remove of the last entry also move entries between the
// stacks: begin every entry in front of the cursor, end every entry behind
// it, and such a remove every remaining entry, since the stack chains move
// one entry between them per cycle. One request is in work at a time, so a
// new request is taken only once the last one's result is loaded; in_ready
// is high while the sequencer is idle.
// Reset empties the list and puts the cursor at 0; entry contents are not
// cleared and never show. When the receiver stalls, the result waits in the
// output register and the sequencer holds until it can hand over the next one.
module cursor_list_buffer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clb_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output clb_pkg::out_item_t out_data
);

  clb_pkg::ctl_state_t state_r, state_nxt;
  logic [clb_pkg::CNT_W-1:0]  lc_r, lc_nxt;
  logic [clb_pkg::CNT_W-1:0]  rc_r, rc_nxt;
  logic                       ok_r, ok_nxt;
  logic [clb_pkg::DATA_W-1:0] removed_r, removed_nxt;
  logic                       out_valid_r, out_valid_nxt;
  clb_pkg::out_item_t         out_r, out_nxt;
  logic                       out_load;

  clb_pkg::stk_ctl_t          l_ctl, r_ctl;
  logic [clb_pkg::DATA_W-1:0] l_top, r_top;
  logic [clb_pkg::CNT_W-1:0]  total_w;
  logic                       full_w;
  logic                       empty_w;

  // Two stack chains on either side of the cursor.
  clb_stack u_left (
    .clk      (clk),
    .ctl      (l_ctl),
    .top_data (l_top)
  );

  clb_stack u_right (
    .clk      (clk),
    .ctl      (r_ctl),
    .top_data (r_top)
  );

  assign total_w = lc_r + rc_r;
  assign full_w  = (total_w == clb_pkg::CNT_W'(clb_pkg::CAPACITY));
  assign empty_w = (total_w == '0);

  // Sequencer: applies the action, then moves entries one per cycle if needed.
  always_comb begin
    state_nxt   = state_r;
    lc_nxt      = lc_r;
    rc_nxt      = rc_r;
    ok_nxt      = ok_r;
    removed_nxt = removed_r;
    l_ctl       = '{op: clb_pkg::STK_HOLD, push_data: r_top};
    r_ctl       = '{op: clb_pkg::STK_HOLD, push_data: l_top};
    in_ready    = 1'b0;
    out_load    = 1'b0;

    unique case (state_r)
      clb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ok_nxt      = 1'b0;
          removed_nxt = '0;
          state_nxt   = clb_pkg::ST_DONE;
          unique case (in_data.action)
            clb_pkg::ACT_BEGIN: begin
              if (!empty_w) begin
                ok_nxt = 1'b1;
                if (lc_r != '0) state_nxt = clb_pkg::ST_MOVE_LEFT;
              end
            end
            clb_pkg::ACT_END: begin
              if (!empty_w) begin
                ok_nxt = 1'b1;
                if (rc_r > clb_pkg::CNT_W'(1)) state_nxt = clb_pkg::ST_MOVE_RIGHT;
              end
            end
            clb_pkg::ACT_NEXT: begin
              if (rc_r > clb_pkg::CNT_W'(1)) begin
                ok_nxt   = 1'b1;
                r_ctl.op = clb_pkg::STK_POP;
                l_ctl.op = clb_pkg::STK_PUSH;
                lc_nxt   = lc_r + clb_pkg::CNT_W'(1);
                rc_nxt   = rc_r - clb_pkg::CNT_W'(1);
              end
            end
            clb_pkg::ACT_PRIOR: begin
              if (lc_r != '0) begin
                ok_nxt   = 1'b1;
                l_ctl.op = clb_pkg::STK_POP;
                r_ctl.op = clb_pkg::STK_PUSH;
                lc_nxt   = lc_r - clb_pkg::CNT_W'(1);
                rc_nxt   = rc_r + clb_pkg::CNT_W'(1);
              end
            end
            clb_pkg::ACT_INSERT_AFTER: begin
              if (empty_w) begin
                ok_nxt          = 1'b1;
                r_ctl.op        = clb_pkg::STK_PUSH;
                r_ctl.push_data = in_data.value;
                rc_nxt          = clb_pkg::CNT_W'(1);
              end else if (!full_w) begin
                // The old cursor byte moves in front; the new byte takes the top.
                ok_nxt          = 1'b1;
                l_ctl.op        = clb_pkg::STK_PUSH;
                r_ctl.op        = clb_pkg::STK_WRITE;
                r_ctl.push_data = in_data.value;
                lc_nxt          = lc_r + clb_pkg::CNT_W'(1);
              end
            end
            clb_pkg::ACT_INSERT_BEFORE: begin
              if (!full_w) begin
                ok_nxt          = 1'b1;
                r_ctl.op        = clb_pkg::STK_PUSH;
                r_ctl.push_data = in_data.value;
                rc_nxt          = rc_r + clb_pkg::CNT_W'(1);
              end
            end
            clb_pkg::ACT_REMOVE: begin
              if (!empty_w) begin
                ok_nxt      = 1'b1;
                removed_nxt = r_top;
                r_ctl.op    = clb_pkg::STK_POP;
                rc_nxt      = rc_r - clb_pkg::CNT_W'(1);
                // Removing the last entry sends the cursor back to the start.
                if (rc_r == clb_pkg::CNT_W'(1) && lc_r != '0) begin
                  state_nxt = clb_pkg::ST_MOVE_LEFT;
                end
              end
            end
            clb_pkg::ACT_REPLACE: begin
              if (!empty_w) begin
                ok_nxt          = 1'b1;
                r_ctl.op        = clb_pkg::STK_WRITE;
                r_ctl.push_data = in_data.value;
              end
            end
            default: begin
              state_nxt = clb_pkg::ST_DONE;
            end
          endcase
        end
      end
      clb_pkg::ST_MOVE_LEFT: begin
        l_ctl.op = clb_pkg::STK_POP;
        r_ctl.op = clb_pkg::STK_PUSH;
        lc_nxt   = lc_r - clb_pkg::CNT_W'(1);
        rc_nxt   = rc_r + clb_pkg::CNT_W'(1);
        if (lc_r == clb_pkg::CNT_W'(1)) state_nxt = clb_pkg::ST_DONE;
      end
      clb_pkg::ST_MOVE_RIGHT: begin
        r_ctl.op = clb_pkg::STK_POP;
        l_ctl.op = clb_pkg::STK_PUSH;
        lc_nxt   = lc_r + clb_pkg::CNT_W'(1);
        rc_nxt   = rc_r - clb_pkg::CNT_W'(1);
        if (rc_r == clb_pkg::CNT_W'(2)) state_nxt = clb_pkg::ST_DONE;
      end
      clb_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = clb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = clb_pkg::ST_IDLE;
      end
    endcase
  end

  // Result register, loaded once the list has settled.
  always_comb begin
    out_nxt.ok              = ok_r;
    out_nxt.removed_value   = removed_r;
    out_nxt.cursor_value    = empty_w ? '0 : r_top;
    out_nxt.cursor_position = lc_r[clb_pkg::POS_W-1:0];
    out_nxt.entry_count     = total_w;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clb_pkg::ST_IDLE;
      lc_r        <= '0;
      rc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lc_r        <= lc_nxt;
      rc_r        <= rc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r      <= ok_nxt;
    removed_r <= removed_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The two stacks never hold more than the capacity between them.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_w <= clb_pkg::CNT_W'(clb_pkg::CAPACITY))
    else $error("list count above capacity");

  // A non-empty list always has an entry under the cursor when idle.
  a_cursor_on_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clb_pkg::ST_IDLE && !empty_w) |-> (rc_r != '0))
    else $error("cursor past the last entry");

  // Moving toward the start only runs while entries remain in front.
  a_move_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clb_pkg::ST_MOVE_LEFT) |-> (lc_r != '0))
    else $error("move toward start with nothing in front");

  // Moving toward the end stops with one entry left at the cursor.
  a_move_right: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == clb_pkg::ST_MOVE_RIGHT) |-> (rc_r > clb_pkg::CNT_W'(1)))
    else $error("move toward end past the last entry");

  // A result appears only after the sequencer finished a request.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == clb_pkg::ST_DONE))
    else $error("result without a finished request");

endmodule

// ===== bench/tb_cursor_list_buffer_unit.sv =====
// Self-checking bench for cursor_list_buffer_unit: directed list edits, then
// weighted random fill, drain and mixed phases with random stalls on both sides.
// Depends on clb_pkg and the cursor_list_buffer_unit RTL.
module tb_cursor_list_buffer_unit;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_REQUESTS = 750;
  localparam int REPORT_LIMIT = 10;

  // Tracks the list contents and holds the results owed by the block.
  class list_scoreboard;
    logic [clb_pkg::DATA_W-1:0] list_bytes[clb_pkg::CAPACITY];
    int unsigned list_len = 0;
    int unsigned cur_pos = 0;
    int mismatches = 0;
    clb_pkg::out_item_t owed_results[$];

    function int pending();
      return owed_results.size();
    endfunction

    // Applies an accepted request to the list copy and queues its result.
    function void note_request(clb_pkg::in_item_t req);
      clb_pkg::out_item_t res;
      logic ok;
      logic [clb_pkg::DATA_W-1:0] taken;
      int unsigned slot;
      int unsigned i;
      ok = 1'b0;
      taken = '0;
      case (req.action)
        clb_pkg::ACT_BEGIN: begin
          if (list_len > 0) begin
            cur_pos = 0;
            ok = 1'b1;
          end
        end
        clb_pkg::ACT_END: begin
          if (list_len > 0) begin
            cur_pos = list_len - 1;
            ok = 1'b1;
          end
        end
        clb_pkg::ACT_NEXT: begin
          if (list_len > 0 && cur_pos + 1 < list_len) begin
            cur_pos = cur_pos + 1;
            ok = 1'b1;
          end
        end
        clb_pkg::ACT_PRIOR: begin
          if (list_len > 0 && cur_pos > 0) begin
            cur_pos = cur_pos - 1;
            ok = 1'b1;
          end
        end
        clb_pkg::ACT_INSERT_AFTER, clb_pkg::ACT_INSERT_BEFORE: begin
          if (list_len == 0) begin
            list_bytes[0] = req.value;
            list_len = 1;
            cur_pos = 0;
            ok = 1'b1;
          end else if (list_len < clb_pkg::CAPACITY) begin
            slot = (req.action == clb_pkg::ACT_INSERT_AFTER) ? cur_pos + 1 : cur_pos;
            for (i = list_len; i > slot; i--) list_bytes[i] = list_bytes[i-1];
            list_bytes[slot] = req.value;
            list_len = list_len + 1;
            cur_pos = slot;
            ok = 1'b1;
          end
        end
        clb_pkg::ACT_REMOVE: begin
          if (list_len > 0) begin
            taken = list_bytes[cur_pos];
            for (i = cur_pos; i + 1 < list_len; i++) list_bytes[i] = list_bytes[i+1];
            list_len = list_len - 1;
            // The cursor lands on the following entry, or wraps when none is left.
            if (cur_pos >= list_len) cur_pos = 0;
            ok = 1'b1;
          end
        end
        default: begin
          if (list_len > 0) begin
            list_bytes[cur_pos] = req.value;
            ok = 1'b1;
          end
        end
      endcase
      if (list_len == 0) cur_pos = 0;
      res.ok = ok;
      res.removed_value = taken;
      res.cursor_value = (list_len > 0) ? list_bytes[cur_pos] : '0;
      res.cursor_position = cur_pos[5:0];
      res.entry_count = list_len[6:0];
      owed_results.push_back(res);
    endfunction

    // Compares one handed-over result with the oldest owed one.
    function void check_result(clb_pkg::out_item_t got);
      clb_pkg::out_item_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result with no request pending: %h", got);
        return;
      end
      want = owed_results.pop_front();
      if (got.ok !== want.ok || got.removed_value !== want.removed_value ||
          got.cursor_value !== want.cursor_value ||
          got.cursor_position !== want.cursor_position ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"mismatch (expected/actual): ok %0b/%0b removed %02h/%02h ",
                    "value %02h/%02h pos %0d/%0d count %0d/%0d"},
                   want.ok, got.ok, want.removed_value, got.removed_value,
                   want.cursor_value, got.cursor_value,
                   want.cursor_position, got.cursor_position,
                   want.entry_count, got.entry_count);
      end
    endfunction
  endclass

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  clb_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  clb_pkg::out_item_t out_data;

  list_scoreboard sb = new();
  int cycle_count = 0;
  int send_quiet = 0;
  int results_seen = 0;

  cursor_list_buffer_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_cursor_list_buffer_unit: errors");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [clb_pkg::DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return clb_pkg::DATA_W'($urandom_range(0, 255));
  endfunction

  // Offers one request, holds it until accepted, then idles at random.
  task automatic send_request(clb_pkg::in_item_t req);
    int gap;
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req);
    if (send_quiet > 0) begin
      send_quiet--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 99) < 2) send_quiet = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_action(clb_pkg::action_t act, logic [clb_pkg::DATA_W-1:0] value);
    clb_pkg::in_item_t req;
    req.action = act;
    req.value = value;
    send_request(req);
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic drain_requests();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: checks each handed-over result and stalls at random,
  // with one long hold-off that backs the block up into its input.
  initial begin
    int stall_left;
    int quiet_left;
    bit held;
    stall_left = 0;
    quiet_left = 0;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        sb.check_result(out_data);
        results_seen++;
      end
      if (!held && results_seen >= 300) begin
        held = 1'b1;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (quiet_left > 0) begin
        quiet_left--;
        out_ready <= 1'b1;
      end else begin
        if ($urandom_range(0, 99) < 2) quiet_left = $urandom_range(50, 150);
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Request side: reset, directed edits, then random phases.
  initial begin
    clb_pkg::in_item_t req;
    mix_mode_t mode;
    int bound_hits;
    int mix_left;
    int r;
    int n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every action but the inserts is refused on an empty list.
    send_action(clb_pkg::ACT_BEGIN, 8'h00);
    send_action(clb_pkg::ACT_END, 8'hFF);
    send_action(clb_pkg::ACT_NEXT, 8'h00);
    send_action(clb_pkg::ACT_PRIOR, 8'hFF);
    send_action(clb_pkg::ACT_REMOVE, 8'hFF);
    send_action(clb_pkg::ACT_REPLACE, 8'hFF);
    // Insert into an empty list, then remove the only entry.
    send_action(clb_pkg::ACT_INSERT_BEFORE, 8'h00);
    send_action(clb_pkg::ACT_REMOVE, 8'h00);
    send_action(clb_pkg::ACT_INSERT_AFTER, 8'hFF);
    send_action(clb_pkg::ACT_INSERT_AFTER, 8'h80);
    send_action(clb_pkg::ACT_INSERT_BEFORE, 8'h7F);
    send_action(clb_pkg::ACT_INSERT_BEFORE, 8'h01);
    // Walk to the end and past it, then back past the front.
    send_action(clb_pkg::ACT_NEXT, 8'h00);
    send_action(clb_pkg::ACT_NEXT, 8'h00);
    send_action(clb_pkg::ACT_NEXT, 8'h00);
    send_action(clb_pkg::ACT_PRIOR, 8'h00);
    send_action(clb_pkg::ACT_BEGIN, 8'h00);
    send_action(clb_pkg::ACT_PRIOR, 8'h00);
    send_action(clb_pkg::ACT_REPLACE, 8'hAA);
    // Removing the last entry wraps the cursor; removing the first keeps it.
    send_action(clb_pkg::ACT_END, 8'h00);
    send_action(clb_pkg::ACT_REMOVE, 8'h00);
    send_action(clb_pkg::ACT_REMOVE, 8'h00);
    send_action(clb_pkg::ACT_REPLACE, 8'h55);
    drain_requests();

    // Fill to capacity, drain to empty, and mix freely in between.
    mode = MODE_FILL;
    bound_hits = 0;
    mix_left = 0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 500) drain_requests();
      case (mode)
        MODE_FILL: begin
          if (sb.list_len == clb_pkg::CAPACITY) bound_hits++;
          if (bound_hits > 4) begin
            mode = MODE_DRAIN;
            bound_hits = 0;
          end
        end
        MODE_DRAIN: begin
          if (sb.list_len == 0) bound_hits++;
          if (bound_hits > 4) begin
            mode = MODE_MIX;
            bound_hits = 0;
            mix_left = $urandom_range(40, 120);
          end
        end
        default: begin
          if (mix_left == 0) mode = MODE_FILL;
          else mix_left--;
        end
      endcase
      r = $urandom_range(0, 99);
      req.action = clb_pkg::action_t'($urandom_range(0, 7));
      if (mode == MODE_FILL && r < 75)
        req.action = $urandom_range(0, 1) ? clb_pkg::ACT_INSERT_AFTER
                                          : clb_pkg::ACT_INSERT_BEFORE;
      else if (mode == MODE_DRAIN && r < 75)
        req.action = clb_pkg::ACT_REMOVE;
      req.value = pick_value();
      send_request(req);
    end

    drain_requests();
    repeat (100) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_cursor_list_buffer_unit: clean");
    end else begin
      $display("tb_cursor_list_buffer_unit: errors");
    end
    $finish;
  end

endmodule

// ===== cursor_list_buffer_unit.f =====
rtl/clb_pkg.sv
rtl/clb_cell.sv
rtl/clb_stack.sv
rtl/cursor_list_buffer_unit.sv
bench/tb_cursor_list_buffer_unit.sv
